// ===== hdl/window_cooccurrence_edges_core_assert.svh =====
// ----------------------------------------------------------------------------
// Window co-occurrence edges assertion macros
// Concurrent assertion shorthands clocked by clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_COOCCURRENCE_EDGES_CORE_ASSERT_SVH
`define WINDOW_COOCCURRENCE_EDGES_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("window_cooccurrence_edges_core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("window_cooccurrence_edges_core assertion failed");

`endif

// ===== hdl/wce_pkg.sv =====
// ----------------------------------------------------------------------------
// Window co-occurrence edges package
// Transaction types, controller interface types and the weight table.
// ----------------------------------------------------------------------------
package wce_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned ENT_W    = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam logic [31:0] MAX_DIST_RESET = 32'd5;

  typedef struct packed {
    logic [POS_W-1:0] sentence_pos;
    logic [ENT_W-1:0] entity_id;
  } in_item_t;

  typedef struct packed {
    logic                edge_valid;
    logic [ENT_W-1:0]    source_entity;
    logic [ENT_W-1:0]    target_entity;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                window_overflow;
    logic                last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_WALK_INIT,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic cap_in;
    logic drop_rd;
    logic drop;
    logic walk_init;
    logic walk_step;
    logic walk_issue;
    logic walk_take;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic far;
    logic hit;
    logic pend_valid;
    logic out_free;
    logic rem_zero;
  } ctrl_status_t;

  // Rounded exp(-distance) in unsigned Q0.16, saturated at the top.
  function automatic logic [WEIGHT_W-1:0] edge_weight_f(logic [POS_W-1:0] distance);
    logic [WEIGHT_W-1:0] w;
    w = '0;
    if (distance[POS_W-1:4] == '0) begin
      case (distance[3:0])
        4'd0:    w = 16'd65535;
        4'd1:    w = 16'd24109;
        4'd2:    w = 16'd8869;
        4'd3:    w = 16'd3263;
        4'd4:    w = 16'd1200;
        4'd5:    w = 16'd442;
        4'd6:    w = 16'd162;
        4'd7:    w = 16'd60;
        4'd8:    w = 16'd22;
        4'd9:    w = 16'd8;
        4'd10:   w = 16'd3;
        4'd11:   w = 16'd1;
        default: w = 16'd0;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== hdl/wce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wce_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/wce_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window co-occurrence edges controller
// Sequences the prune, walk and append phases of each input transaction.
// ----------------------------------------------------------------------------
module wce_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  wce_pkg::ctrl_status_t status_i,
  output wce_pkg::ctrl_cmd_t    cmd_o
);

  wce_pkg::state_e state_q, state_d;
  logic            walk_hold;

  // The walk holds when a new edge must displace a pending edge that cannot leave.
  assign walk_hold = status_i.hit && status_i.pend_valid && !status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wce_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = wce_pkg::ST_DROP_RD;
      end
      wce_pkg::ST_DROP_RD: begin
        state_d = status_i.count_zero ? wce_pkg::ST_WALK_INIT : wce_pkg::ST_DROP_CHK;
      end
      wce_pkg::ST_DROP_CHK: begin
        state_d = status_i.far ? wce_pkg::ST_DROP_RD : wce_pkg::ST_WALK_INIT;
      end
      wce_pkg::ST_WALK_INIT: begin
        state_d = wce_pkg::ST_WALK;
      end
      wce_pkg::ST_WALK: begin
        if (!walk_hold && status_i.rem_zero) state_d = wce_pkg::ST_FINISH;
      end
      wce_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = wce_pkg::ST_IDLE;
      end
      default: state_d = wce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      wce_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.cap_in = in_valid_i;
      end
      wce_pkg::ST_DROP_RD: begin
        cmd_o.drop_rd = !status_i.count_zero;
      end
      wce_pkg::ST_DROP_CHK: begin
        cmd_o.drop = status_i.far;
      end
      wce_pkg::ST_WALK_INIT: begin
        cmd_o.walk_init = 1'b1;
      end
      wce_pkg::ST_WALK: begin
        cmd_o.walk_step  = !walk_hold;
        cmd_o.walk_issue = !walk_hold && !status_i.rem_zero;
        cmd_o.walk_take  = !walk_hold && status_i.hit;
      end
      wce_pkg::ST_FINISH: begin
        cmd_o.finish = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/wce_dp.sv =====
// ----------------------------------------------------------------------------
// Window co-occurrence edges datapath
// Window memory and pointers, distance checks, pending edge and output stage.
// ----------------------------------------------------------------------------
module wce_dp #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wce_pkg::in_item_t     in_data_i,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  wce_pkg::ctrl_cmd_t    cmd_i,
  output wce_pkg::ctrl_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wce_pkg::out_item_t    out_data_o
);

  localparam int unsigned IDX_W   = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned ENTRY_W = wce_pkg::POS_W + wce_pkg::ENT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(WINDOW_DEPTH);

  logic [31:0]               max_dist_q, max_dist_d;
  logic [wce_pkg::POS_W-1:0] cur_pos_q;
  logic [wce_pkg::ENT_W-1:0] cur_ent_q;
  logic [IDX_W-1:0]          head_q, head_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [IDX_W-1:0]          ptr_q, ptr_d;
  logic [CNT_W-1:0]          rem_q, rem_d;
  logic                      rdv_q, rdv_d;
  logic                      ovf_q, ovf_d;
  logic                      pend_v_q, pend_v_d;
  wce_pkg::out_item_t        pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;
  wce_pkg::out_item_t        out_q, out_d;

  logic                      full;
  logic                      out_free;
  logic                      push;
  logic [ENTRY_W-1:0]        rd_entry;
  logic [wce_pkg::POS_W-1:0] rd_pos;
  logic [wce_pkg::ENT_W-1:0] rd_ent;
  logic [wce_pkg::POS_W-1:0] pos_delta;
  logic [SUM_W-1:0]          tail_sum;
  logic [IDX_W-1:0]          tail_idx;
  logic [IDX_W-1:0]          raddr;
  wce_pkg::out_item_t        new_edge;

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign full      = (count_q == DEPTH_C);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rd_pos    = rd_entry[ENTRY_W-1 -: wce_pkg::POS_W];
  assign rd_ent    = rd_entry[wce_pkg::ENT_W-1:0];
  assign pos_delta = cur_pos_q - rd_pos;
  assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail_idx  = full ? head_q
                   : ((tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum));
  assign raddr     = cmd_i.drop_rd ? head_q : ptr_q;

  wce_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.finish),
    .waddr_i(tail_idx),
    .wdata_i({cur_pos_q, cur_ent_q}),
    .re_i   (cmd_i.drop_rd || cmd_i.walk_issue),
    .raddr_i(raddr),
    .rdata_o(rd_entry)
  );

  always_comb begin
    new_edge                 = '0;
    new_edge.edge_valid      = 1'b1;
    new_edge.source_entity   = rd_ent;
    new_edge.target_entity   = cur_ent_q;
    new_edge.edge_weight     = wce_pkg::edge_weight_f(pos_delta);
    new_edge.window_overflow = ovf_q;
  end

  always_comb begin
    status_o            = '0;
    status_o.count_zero = (count_q == '0);
    status_o.far        = pos_delta > max_dist_q;
    status_o.hit        = rdv_q && (rd_ent != cur_ent_q) && !(rd_pos > cur_pos_q);
    status_o.pend_valid = pend_v_q;
    status_o.out_free   = out_free;
    status_o.rem_zero   = (rem_q == '0);
  end

  always_comb begin
    max_dist_d  = cfg_we_i ? cfg_wdata_i : max_dist_q;
    head_d      = head_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    rdv_d       = rdv_q;
    ovf_d       = ovf_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_d       = out_q;
    push        = 1'b0;

    if (cmd_i.drop) begin
      head_d  = wrap_inc(head_q);
      count_d = count_q - 1'b1;
    end

    if (cmd_i.walk_init) begin
      ptr_d    = head_q;
      rem_d    = count_q;
      rdv_d    = 1'b0;
      ovf_d    = full;
      pend_v_d = 1'b0;
    end

    if (cmd_i.walk_step) begin
      rdv_d = cmd_i.walk_issue;
    end

    if (cmd_i.walk_issue) begin
      ptr_d = wrap_inc(ptr_q);
      rem_d = rem_q - 1'b1;
    end

    if (cmd_i.walk_take) begin
      if (pend_v_q) begin
        push  = 1'b1;
        out_d = pend_q;
      end
      pend_d   = new_edge;
      pend_v_d = 1'b1;
    end

    if (cmd_i.finish) begin
      push = 1'b1;
      if (pend_v_q) begin
        out_d = pend_q;
      end else begin
        out_d                 = '0;
        out_d.window_overflow = ovf_q;
      end
      out_d.last_of_run = 1'b1;
      pend_v_d          = 1'b0;
      if (full) begin
        head_d = wrap_inc(head_q);
      end else begin
        count_d = count_q + 1'b1;
      end
    end

    out_valid_d = push || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= wce_pkg::MAX_DIST_RESET;
      head_q      <= '0;
      count_q     <= '0;
      rdv_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      max_dist_q  <= max_dist_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rdv_q       <= rdv_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      cur_pos_q <= in_data_i.sentence_pos;
      cur_ent_q <= in_data_i.entity_id;
    end
    ptr_q  <= ptr_d;
    rem_q  <= rem_d;
    ovf_q  <= ovf_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/window_cooccurrence_edges_core.sv =====
// Each input is pruned (the oldest entry is read, then checked), walked over the kept entries, then appended.
// The core takes a new input transaction only after the previous one has finished.
// The pace is set by the single read port of the window memory.
// A walk pauses only while a finished result is stalled and a newer edge waits behind it.
// Reset empties the window, clears the output stage and sets the distance limit to 5.
// The window memory is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// Window co-occurrence edges core
// Emits weighted co-occurrence edges against a sliding window of occurrences.
// ----------------------------------------------------------------------------
module window_cooccurrence_edges_core #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wce_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wce_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);

  wce_pkg::ctrl_cmd_t    cmd;
  wce_pkg::ctrl_status_t status;

  wce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wce_dp #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/wce_checker.sv =====
// ----------------------------------------------------------------------------
// Window co-occurrence edges checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "window_cooccurrence_edges_core_assert.svh"

module wce_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input wce_pkg::out_item_t out_data_o
);

  `WCE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  `WCE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  `WCE_ASSERT_SAME(a_marker_shape, out_valid_o && !out_data_o.edge_valid, out_data_o.last_of_run && (out_data_o.source_entity == '0) && (out_data_o.edge_weight == '0))

  `WCE_ASSERT_SAME(a_no_self_edge, out_valid_o && out_data_o.edge_valid, out_data_o.source_entity != out_data_o.target_entity)

endmodule

bind window_cooccurrence_edges_core wce_checker u_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Window co-occurrence edges testbench
// Drives occurrence transactions into the core with random idle cycles and
// receiver stalls. A behavioral window predicts every edge result, and each
// result transaction is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH         = 64;
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam logic [31:0] DIST_ALL      = 32'hFFFF_FFFF;
  localparam logic [wce_pkg::WEIGHT_W-1:0] DECAY [12] = '{
    16'd65535, 16'd24109, 16'd8869, 16'd3263, 16'd1200, 16'd442,
    16'd162, 16'd60, 16'd22, 16'd8, 16'd3, 16'd1
  };

  logic               clk_i;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  wce_pkg::in_item_t  in_data     = '0;
  logic               out_stall   = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [31:0]        cfg_wdata   = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  wce_pkg::out_item_t out_data_o;

  logic               quiet        = 1'b0;
  logic               hold_request = 1'b0;
  int                 fail_count   = 0;
  wce_pkg::out_item_t expected_edges[$];

  logic [31:0] max_dist;
  logic [31:0] win_pos[DEPTH];
  logic [31:0] win_ent[DEPTH];
  int unsigned win_head;
  int unsigned win_count;

  window_cooccurrence_edges_core #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_edges(wce_pkg::in_item_t item);
    logic [31:0]        d;
    logic [31:0]        epos;
    logic [31:0]        eent;
    logic               ovf;
    int unsigned        s;
    int                 n;
    wce_pkg::out_item_t r;
    while (win_count > 0) begin
      d = item.sentence_pos - win_pos[win_head];
      if (d <= max_dist) break;
      win_head = (win_head + 1) % DEPTH;
      win_count--;
    end
    ovf = (win_count >= DEPTH);
    n = 0;
    for (int unsigned i = 0; i < win_count; i++) begin
      s = (win_head + i) % DEPTH;
      epos = win_pos[s];
      eent = win_ent[s];
      if (eent != item.entity_id && epos <= item.sentence_pos) begin
        d = item.sentence_pos - epos;
        r.edge_valid      = 1'b1;
        r.source_entity   = eent;
        r.target_entity   = item.entity_id;
        r.edge_weight     = (d < 12) ? DECAY[d] : '0;
        r.window_overflow = ovf;
        r.last_of_run     = 1'b0;
        expected_edges.push_back(r);
        n++;
      end
    end
    if (n == 0) begin
      r = '0;
      r.window_overflow = ovf;
      expected_edges.push_back(r);
    end
    expected_edges[expected_edges.size() - 1].last_of_run = 1'b1;
    if (win_count >= DEPTH) begin
      win_head = (win_head + 1) % DEPTH;
      win_count--;
    end
    s = (win_head + win_count) % DEPTH;
    win_pos[s] = item.sentence_pos;
    win_ent[s] = item.entity_id;
    win_count++;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_occurrence(input logic [31:0] pos, input logic [31:0] ent);
    wce_pkg::in_item_t item;
    item.sentence_pos = pos;
    item.entity_id    = ent;
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_edges(item);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_max_distance(input logic [31:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    max_dist = value;
  endtask

  task automatic test_empty_and_self();
    send_occurrence(32'd10, 32'd7);
    send_occurrence(32'd10, 32'd7);
    send_occurrence(32'd11, 32'd9);
    send_occurrence(32'd20, 32'd9);
  endtask

  task automatic test_weights();
    int unsigned steps[10];
    steps = '{0, 1, 2, 3, 5, 8, 11, 12, 15, 16};
    set_max_distance(32'd20);
    send_occurrence(32'd1000, 32'd0);
    foreach (steps[i]) send_occurrence(32'd1000 + steps[i], 32'hFFFF_FFFF);
  endtask

  task automatic test_wrap_and_late();
    set_max_distance(DIST_ALL);
    send_occurrence(32'hFFFF_FFFE, 32'd5);
    send_occurrence(32'd1, 32'd6);
    send_occurrence(32'd0, 32'd8);
  endtask

  task automatic test_zero_distance();
    set_max_distance(32'd0);
    send_occurrence(32'd500, 32'd1);
    send_occurrence(32'd500, 32'd2);
    send_occurrence(32'd500, 32'd1);
    send_occurrence(32'd501, 32'd2);
  endtask

  task automatic test_window_overflow();
    set_max_distance(DIST_ALL);
    for (int i = 0; i < 70; i++) send_occurrence(32'd77, 32'd1000 + i);
  endtask

  task automatic test_random_phase(input logic [31:0] limit, input int count);
    logic [31:0] pool[8];
    logic [31:0] pos;
    logic [31:0] ent;
    int unsigned roll;
    set_max_distance(limit);
    foreach (pool[i]) pool[i] = (i < 4) ? $urandom : $urandom_range(15);
    pos = $urandom;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      ent = pool[$urandom_range(7)];
      if (roll < 85) begin
        pos += ($urandom_range(9) == 0) ? $urandom_range(3, 30) : $urandom_range(0, 2);
      end else if (roll < 93) begin
        pos = $urandom;
      end else begin
        ent = $urandom;
      end
      send_occurrence(pos, ent);
    end
  endtask

  task automatic test_backpressure();
    set_max_distance(DIST_ALL);
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_occurrence(32'd4000 + i / 4, $urandom_range(20));
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 17);
      end
    end
  end

  initial begin : result_check
    wce_pkg::out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_n && out_valid_o && !out_stall) begin
        if (expected_edges.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_edges.pop_front();
          check_field("edge_valid", 32'(want.edge_valid), 32'(out_data_o.edge_valid));
          check_field("source_entity", want.source_entity, out_data_o.source_entity);
          check_field("target_entity", want.target_entity, out_data_o.target_entity);
          check_field("edge_weight", 32'(want.edge_weight), 32'(out_data_o.edge_weight));
          check_field("window_overflow", 32'(want.window_overflow),
                      32'(out_data_o.window_overflow));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_data_o.last_of_run));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : test_sequence
    max_dist  = wce_pkg::MAX_DIST_RESET;
    win_head  = 0;
    win_count = 0;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_empty_and_self();
    test_weights();
    test_wrap_and_late();
    test_zero_distance();
    test_window_overflow();
    test_random_phase(32'd5, 58);
    test_random_phase(32'd0, 58);
    quiet = 1'b1;
    test_random_phase(DIST_ALL, 58);
    quiet = 1'b0;
    test_random_phase(32'd12, 58);
    test_random_phase($urandom_range(1, 40), 58);
    test_random_phase($urandom, 58);
    test_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
